// ----- design/ntcah_pkg.sv -----
// Shared types, constants and the log2 table builder for the NTC heater controller.
package ntcah_pkg;

   localparam int AVG_SAMPLES_DEF     = 50;
   localparam int LOG_TABLE_DEPTH_DEF = 256;

   // Datapath widths and constants.
   localparam int                 TW             = 62;
   localparam logic signed [61:0] VERY_LOW_CENTI = -62'sd1000000;
   localparam logic [23:0]        LN2_Q24        = 24'd11629080;
   localparam int                 DIV_STEPS      = 60;
   localparam int                 CSR_DW         = 20;

   typedef enum logic [2:0] {
      CSR_ENABLE  = 3'd0,
      CSR_DUTY    = 3'd1,
      CSR_ON_OFS  = 3'd2,
      CSR_OFF_OFS = 3'd3,
      CSR_CURRENT = 3'd4,
      CSR_REF_RES = 3'd5,
      CSR_BETA    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic        control_enable;
      logic [7:0]  on_duty;
      logic [10:0] on_offset_centi;
      logic [10:0] off_offset_centi;
      logic [19:0] excite_current_na;
      logic [19:0] ref_resistance_ohm;
      logic [12:0] beta_kelvin;
   } cfg_type;

   typedef enum logic [4:0] {
      OP_IDLE, OP_ACCUM, OP_MUL1, OP_MUL2, OP_LOADX, OP_NORM, OP_LOGMUL, OP_RD0,
      OP_RD1, OP_INTERP, OP_LOGSUM, OP_MAG, OP_LN, OP_DD1, OP_DD2, OP_DIVINIT,
      OP_DIVSTEP, OP_TSUB, OP_LOW, OP_CTRL
   } op_type;

   typedef struct packed {
      op_type op;
      logic   sel;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic fault;
      logic den_zero;
      logic norm_done;
      logic dd_nonpos;
      logic div_last;
      logic out_busy;
   } status_type;

   // Fraction of log2 by repeated squaring, evaluated on constants only.
   function automatic logic [24:0] log_frac(input logic [63:0] y0);
      logic [63:0] y;
      logic [24:0] f;
      y = y0;
      f = '0;
      for (int i = 0; i < 24; i++) begin
         y = (y * y) >> 30;
         f = {f[23:0], 1'b0};
         if (y >= 64'h80000000) begin
            y = y >> 1;
            f[0] = 1'b1;
         end
      end
      return f;
   endfunction

endpackage

// ----- design/ntc_averaged_hysteresis_heater.sv -----
// Top level of the averaged NTC thermistor heater controller.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_sample_uv, req_setpoint_centi
//   rsp      out        rsp_valid / rsp_stall  rsp_heater_duty, rsp_temperature_centi,
//                                              rsp_sensor_fault
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// While accumulating, the block can take a new sample as soon as it has added the last one.
// An evaluation normalizes the two log2 operands by shifting one bit a cycle, then
// runs the 60-step divider.
// Reset is synchronous and clears the sum, the count, the heater state and rsp_valid.
// A result waiting under rsp_stall holds its register; accumulation continues meanwhile.
module ntc_averaged_hysteresis_heater #(
   parameter int AVG_SAMPLES     = ntcah_pkg::AVG_SAMPLES_DEF,
   parameter int LOG_TABLE_DEPTH = ntcah_pkg::LOG_TABLE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [21:0]                  req_sample_uv,
   input  logic [13:0]                  req_setpoint_centi,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_heater_duty,
   output logic signed [14:0]           rsp_temperature_centi,
   output logic                         rsp_sensor_fault,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [2:0]                   csr_index,
   input  logic [ntcah_pkg::CSR_DW-1:0] csr_data
);

   ntcah_pkg::cfg_type    cfg;
   ntcah_pkg::cmd_type    cmd;
   ntcah_pkg::status_type status;

   ntcah_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ntcah_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ntcah_dp #(
      .AVG   (AVG_SAMPLES),
      .DEPTH (LOG_TABLE_DEPTH)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg),
      .cmd                   (cmd),
      .status                (status),
      .req_sample_uv         (req_sample_uv),
      .req_setpoint_centi    (req_setpoint_centi),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_heater_duty       (rsp_heater_duty),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_sensor_fault      (rsp_sensor_fault)
   );

endmodule

// ----- design/ntcah_csr.sv -----
// Configuration register file for the NTC heater controller.
module ntcah_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [2:0]                    csr_index,
   input  logic [ntcah_pkg::CSR_DW-1:0]  csr_data,
   output ntcah_pkg::cfg_type            cfg
);

   ntcah_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ntcah_pkg::CSR_ENABLE:  cfg_in.control_enable     = csr_data[0];
            ntcah_pkg::CSR_DUTY:    cfg_in.on_duty            = csr_data[7:0];
            ntcah_pkg::CSR_ON_OFS:  cfg_in.on_offset_centi    = csr_data[10:0];
            ntcah_pkg::CSR_OFF_OFS: cfg_in.off_offset_centi   = csr_data[10:0];
            ntcah_pkg::CSR_CURRENT: cfg_in.excite_current_na  = csr_data[19:0];
            ntcah_pkg::CSR_REF_RES: cfg_in.ref_resistance_ohm = csr_data[19:0];
            ntcah_pkg::CSR_BETA:    cfg_in.beta_kelvin        = csr_data[12:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.control_enable     <= 1'b1;
         cfg_ff.on_duty            <= 8'd5;
         cfg_ff.on_offset_centi    <= 11'd200;
         cfg_ff.off_offset_centi   <= 11'd150;
         cfg_ff.excite_current_na  <= 20'd101440;
         cfg_ff.ref_resistance_ohm <= 20'd10341;
         cfg_ff.beta_kelvin        <= 13'd3576;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- design/ntcah_ctrl.sv -----
// Sequencing state machine for accumulation and temperature evaluation.
module ntcah_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ntcah_pkg::status_type status,
   output ntcah_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_MUL1, ST_MUL2, ST_CHK0, ST_LOADX, ST_NORM, ST_LOGMUL, ST_RD0,
      ST_RD1, ST_INTERP, ST_LOGSUM, ST_MAG, ST_LN, ST_DD1, ST_DD2, ST_CHK1,
      ST_DIVINIT, ST_DIV, ST_TSUB, ST_LOW, ST_CTRL
   } state_type;

   state_type state_ff, state_in;
   logic      sel_ff, sel_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      cmd.op   = ntcah_pkg::OP_IDLE;
      cmd.sel  = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = ntcah_pkg::OP_ACCUM;
               if (status.full) state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.op   = ntcah_pkg::OP_MUL1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.op   = ntcah_pkg::OP_MUL2;
            state_in = ST_CHK0;
         end
         ST_CHK0: begin
            sel_in = 1'b0;
            if (status.fault || status.den_zero) state_in = ST_LOW;
            else                                 state_in = ST_LOADX;
         end
         ST_LOADX: begin
            cmd.op   = ntcah_pkg::OP_LOADX;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            if (status.norm_done) state_in = ST_LOGMUL;
            else                  cmd.op   = ntcah_pkg::OP_NORM;
         end
         ST_LOGMUL: begin
            cmd.op   = ntcah_pkg::OP_LOGMUL;
            state_in = ST_RD0;
         end
         ST_RD0: begin
            cmd.op   = ntcah_pkg::OP_RD0;
            state_in = ST_RD1;
         end
         ST_RD1: begin
            cmd.op   = ntcah_pkg::OP_RD1;
            state_in = ST_INTERP;
         end
         ST_INTERP: begin
            cmd.op   = ntcah_pkg::OP_INTERP;
            state_in = ST_LOGSUM;
         end
         ST_LOGSUM: begin
            cmd.op = ntcah_pkg::OP_LOGSUM;
            if (sel_ff) begin
               state_in = ST_MAG;
            end else begin
               sel_in   = 1'b1;
               state_in = ST_LOADX;
            end
         end
         ST_MAG: begin
            cmd.op   = ntcah_pkg::OP_MAG;
            state_in = ST_LN;
         end
         ST_LN: begin
            cmd.op   = ntcah_pkg::OP_LN;
            state_in = ST_DD1;
         end
         ST_DD1: begin
            cmd.op   = ntcah_pkg::OP_DD1;
            state_in = ST_DD2;
         end
         ST_DD2: begin
            cmd.op   = ntcah_pkg::OP_DD2;
            state_in = ST_CHK1;
         end
         ST_CHK1: begin
            if (status.dd_nonpos) state_in = ST_LOW;
            else                  state_in = ST_DIVINIT;
         end
         ST_DIVINIT: begin
            cmd.op   = ntcah_pkg::OP_DIVINIT;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op = ntcah_pkg::OP_DIVSTEP;
            if (status.div_last) state_in = ST_TSUB;
         end
         ST_TSUB: begin
            cmd.op   = ntcah_pkg::OP_TSUB;
            state_in = ST_CTRL;
         end
         ST_LOW: begin
            cmd.op   = ntcah_pkg::OP_LOW;
            state_in = ST_CTRL;
         end
         ST_CTRL: begin
            // Wait here until the output register is free.
            if (!status.out_busy) begin
               cmd.op   = ntcah_pkg::OP_CTRL;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

// ----- design/ntcah_dp.sv -----
// Datapath: sample sum, log2 units, Beta equation divider and hysteresis output.
module ntcah_dp #(
   parameter int AVG   = ntcah_pkg::AVG_SAMPLES_DEF,
   parameter int DEPTH = ntcah_pkg::LOG_TABLE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ntcah_pkg::cfg_type    cfg,
   input  ntcah_pkg::cmd_type    cmd,
   output ntcah_pkg::status_type status,
   input  logic [21:0]           req_sample_uv,
   input  logic [13:0]           req_setpoint_centi,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_heater_duty,
   output logic signed [14:0]    rsp_temperature_centi,
   output logic                  rsp_sensor_fault
);

   localparam int          KW        = $clog2(DEPTH + 1);
   localparam int          PW        = 30 + KW;
   localparam logic [27:0] FAULT_SUM = 28'(100 * AVG);

   // log2 fraction table, built at elaboration.
   logic [24:0] tab_w [DEPTH+1];
   for (genvar g = 0; g < DEPTH; g++) begin : g_tab
      localparam logic [63:0] Y0 = ((64'(DEPTH) + 64'(g)) << 30) / 64'(DEPTH);
      assign tab_w[g] = ntcah_pkg::log_frac(Y0);
   end
   assign tab_w[DEPTH] = 25'h1000000;

   logic [27:0]        sum_ff, sum_in;
   logic [5:0]         count_ff, count_in;
   logic               heater_ff, heater_in;
   logic               rvalid_ff, rvalid_in;
   logic [13:0]        setpt_ff, setpt_in;
   logic [37:0]        num_ff, num_in;
   logic [39:0]        iprod_ff, iprod_in;
   logic [45:0]        den_ff, den_in;
   logic               fault_ff, fault_in;
   logic [63:0]        x_ff, x_in;
   logic [5:0]         shift_ff, shift_in;
   logic [5:0]         e_ff, e_in;
   logic [PW-1:0]      p_ff, p_in;
   logic [24:0]        tab0_ff, tab0_in, tab1_ff, tab1_in;
   logic [54:0]        interp_ff, interp_in;
   logic [30:0]        la_ff, la_in, lb_ff, lb_in;
   logic [30:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [30:0]        lnm_ff, lnm_in;
   logic signed [46:0] lnprod_ff, lnprod_in;
   logic [19:0]        bk_ff, bk_in;
   logic [27:0]        n2a_ff, n2a_in;
   logic signed [47:0] dd_ff, dd_in;
   logic [58:0]        num2_ff, num2_in;
   logic [59:0]        dvd_ff, dvd_in;
   logic [46:0]        rem_ff, rem_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic signed [61:0] t_ff, t_in;
   logic [7:0]         duty_ff, duty_in;
   logic signed [14:0] temp_ff, temp_in;
   logic               ofault_ff, ofault_in;

   logic [KW-1:0]      k_raw, k_idx, k_nxt;
   logic [30:0]        log_w;
   logic signed [31:0] ln_s;
   logic [34:0]        n2b;
   logic [47:0]        trial;
   logic signed [15:0] on_th, off_th;
   logic signed [61:0] t_sat;

   assign k_raw = p_ff[PW-1:30];
   assign k_idx = (k_raw >= KW'(DEPTH)) ? KW'(DEPTH - 1) : k_raw;
   assign k_nxt = k_idx + KW'(1);
   assign log_w = {e_ff, 24'b0} + 31'(tab0_ff) + 31'(interp_ff[54:30]);
   assign ln_s  = neg_ff ? -$signed({1'b0, lnm_ff}) : $signed({1'b0, lnm_ff});
   assign n2b   = 35'(n2a_ff) * 35'd100;
   assign trial = {rem_ff, dvd_ff[59]};
   assign on_th  = $signed({2'b0, setpt_ff}) - $signed({5'b0, cfg.on_offset_centi});
   assign off_th = $signed({2'b0, setpt_ff}) - $signed({5'b0, cfg.off_offset_centi});

   always_comb begin
      if (t_ff < -62'sd4000)      t_sat = -62'sd4000;
      else if (t_ff > 62'sd15000) t_sat = 62'sd15000;
      else                        t_sat = t_ff;
   end

   always_comb begin
      sum_in    = sum_ff;    count_in  = count_ff;  heater_in = heater_ff;
      rvalid_in = rvalid_ff && rsp_stall;
      setpt_in  = setpt_ff;  num_in    = num_ff;    iprod_in  = iprod_ff;
      den_in    = den_ff;    fault_in  = fault_ff;  x_in      = x_ff;
      shift_in  = shift_ff;  e_in      = e_ff;      p_in      = p_ff;
      tab0_in   = tab0_ff;   tab1_in   = tab1_ff;   interp_in = interp_ff;
      la_in     = la_ff;     lb_in     = lb_ff;     mag_in    = mag_ff;
      neg_in    = neg_ff;    lnm_in    = lnm_ff;    lnprod_in = lnprod_ff;
      bk_in     = bk_ff;     n2a_in    = n2a_ff;    dd_in     = dd_ff;
      num2_in   = num2_ff;   dvd_in    = dvd_ff;    rem_in    = rem_ff;
      cnt_in    = cnt_ff;    t_in      = t_ff;      duty_in   = duty_ff;
      temp_in   = temp_ff;   ofault_in = ofault_ff;
      unique case (cmd.op)
         ntcah_pkg::OP_IDLE: ;
         ntcah_pkg::OP_ACCUM: begin
            if (!status.full) begin
               sum_in   = sum_ff + 28'(req_sample_uv);
               count_in = count_ff + 6'd1;
            end else begin
               setpt_in = req_setpoint_centi;
            end
         end
         ntcah_pkg::OP_MUL1: begin
            num_in   = 38'(sum_ff) * 38'd1000;
            iprod_in = 40'(cfg.excite_current_na) * 40'(cfg.ref_resistance_ohm);
            fault_in = (sum_ff <= FAULT_SUM);
         end
         ntcah_pkg::OP_MUL2: den_in = 46'(iprod_ff) * 46'(AVG);
         ntcah_pkg::OP_LOADX: begin
            x_in     = cmd.sel ? 64'(den_ff) : 64'(num_ff);
            shift_in = '0;
         end
         ntcah_pkg::OP_NORM: begin
            x_in     = {x_ff[62:0], 1'b0};
            shift_in = shift_ff + 6'd1;
         end
         ntcah_pkg::OP_LOGMUL: begin
            p_in = PW'(x_ff[62:33]) * PW'(DEPTH);
            e_in = 6'd63 - shift_ff;
         end
         ntcah_pkg::OP_RD0:    tab0_in   = tab_w[k_idx];
         ntcah_pkg::OP_RD1:    tab1_in   = tab_w[k_nxt];
         ntcah_pkg::OP_INTERP: interp_in = 55'(tab1_ff - tab0_ff) * 55'(p_ff[29:0]);
         ntcah_pkg::OP_LOGSUM: begin
            if (cmd.sel) lb_in = log_w;
            else         la_in = log_w;
         end
         ntcah_pkg::OP_MAG: begin
            neg_in = (lb_ff > la_ff);
            mag_in = (lb_ff > la_ff) ? (lb_ff - la_ff) : (la_ff - lb_ff);
         end
         ntcah_pkg::OP_LN: lnm_in = 31'((55'(mag_ff) * 55'(ntcah_pkg::LN2_Q24)) >> 24);
         ntcah_pkg::OP_DD1: begin
            lnprod_in = 47'(ln_s) * 47'sd29815;
            bk_in     = 20'(cfg.beta_kelvin) * 20'd100;
            n2a_in    = 28'(cfg.beta_kelvin) * 28'd29815;
         end
         ntcah_pkg::OP_DD2: begin
            dd_in   = $signed({4'b0, bk_ff, 24'b0}) + 48'(lnprod_ff);
            num2_in = {n2b, 24'b0};
         end
         ntcah_pkg::OP_DIVINIT: begin
            // Adding half the divisor rounds the quotient, halves up.
            dvd_in = 60'(num2_ff) + 60'(dd_ff[46:1]);
            rem_in = '0;
            cnt_in = 6'(ntcah_pkg::DIV_STEPS);
         end
         ntcah_pkg::OP_DIVSTEP: begin
            if (trial >= {1'b0, dd_ff[46:0]}) begin
               rem_in = 47'(trial - {1'b0, dd_ff[46:0]});
               dvd_in = {dvd_ff[58:0], 1'b1};
            end else begin
               rem_in = trial[46:0];
               dvd_in = {dvd_ff[58:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
         end
         ntcah_pkg::OP_TSUB: t_in = $signed({2'b0, dvd_ff}) - 62'sd27315;
         ntcah_pkg::OP_LOW:  t_in = ntcah_pkg::VERY_LOW_CENTI;
         ntcah_pkg::OP_CTRL: begin
            // The on test has priority when the thresholds cross.
            if (!cfg.control_enable)      heater_in = 1'b0;
            else if (t_ff <= 62'(on_th))  heater_in = 1'b1;
            else if (t_ff >= 62'(off_th)) heater_in = 1'b0;
            duty_in   = heater_in ? cfg.on_duty : 8'd0;
            temp_in   = t_sat[14:0];
            ofault_in = fault_ff;
            rvalid_in = 1'b1;
            sum_in    = '0;
            count_in  = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         count_ff  <= '0;
         heater_ff <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         sum_ff    <= sum_in;
         count_ff  <= count_in;
         heater_ff <= heater_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      setpt_ff  <= setpt_in;  num_ff    <= num_in;    iprod_ff  <= iprod_in;
      den_ff    <= den_in;    fault_ff  <= fault_in;  x_ff      <= x_in;
      shift_ff  <= shift_in;  e_ff      <= e_in;      p_ff      <= p_in;
      tab0_ff   <= tab0_in;   tab1_ff   <= tab1_in;   interp_ff <= interp_in;
      la_ff     <= la_in;     lb_ff     <= lb_in;     mag_ff    <= mag_in;
      neg_ff    <= neg_in;    lnm_ff    <= lnm_in;    lnprod_ff <= lnprod_in;
      bk_ff     <= bk_in;     n2a_ff    <= n2a_in;    dd_ff     <= dd_in;
      num2_ff   <= num2_in;   dvd_ff    <= dvd_in;    rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;    t_ff      <= t_in;      duty_ff   <= duty_in;
      temp_ff   <= temp_in;   ofault_ff <= ofault_in;
   end

   assign status.full      = (count_ff >= 6'(AVG));
   assign status.fault     = fault_ff;
   assign status.den_zero  = (den_ff == '0);
   assign status.norm_done = x_ff[63];
   assign status.dd_nonpos = dd_ff[47] || (dd_ff == '0);
   assign status.div_last  = (cnt_ff == 6'd1);
   assign status.out_busy  = rvalid_ff && rsp_stall;

   assign rsp_valid             = rvalid_ff;
   assign rsp_heater_duty       = duty_ff;
   assign rsp_temperature_centi = temp_ff;
   assign rsp_sensor_fault      = ofault_ff;

endmodule

// ----- design/ntcah_checker.sv -----
// Port-level checker for the NTC heater controller, bound to the top level.
module ntcah_props (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [7:0]         rsp_heater_duty,
   input logic signed [14:0] rsp_temperature_centi,
   input logic               rsp_sensor_fault
);

   // A result held under stall keeps its payload until the transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_heater_duty)
         && $stable(rsp_temperature_centi) && $stable(rsp_sensor_fault))
      else $error("result changed while stalled");

   // A sensor fault reads as the lowest temperature.
   a_fault_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sensor_fault |-> rsp_temperature_centi == -15'sd4000)
      else $error("fault without minimum temperature");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_temperature_centi >= -15'sd4000
         && rsp_temperature_centi <= 15'sd15000)
      else $error("temperature outside saturation range");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind ntc_averaged_hysteresis_heater ntcah_props u_ntcah_props (.*);

// ----- sim/ntcah_checker.sv -----
// Checker for the NTC heater controller: predicts each evaluation and compares results.
module ntcah_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [21:0]       req_sample_uv,
   input  logic [13:0]       req_setpoint_centi,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [7:0]        rsp_heater_duty,
   input  logic signed [14:0] rsp_temperature_centi,
   input  logic              rsp_sensor_fault,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [19:0]       csr_data,
   output int                mismatch_count,
   output int                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSAMP = ntcah_pkg::AVG_SAMPLES_DEF;
   localparam int DEPTH = ntcah_pkg::LOG_TABLE_DEPTH_DEF;
   localparam longint VERY_LOW = -64'sd1000000;

   typedef struct {
      logic [7:0]         duty;
      logic signed [14:0] temp;
      logic               fault;
   } heater_result_type;

   heater_result_type   expected_results[$];
   longint unsigned     frac_table[DEPTH+1];
   ntcah_pkg::cfg_type  cfg;
   logic [27:0]         acc_sum;
   logic [5:0]          acc_count;
   logic                heater_state;

   initial begin
      longint unsigned y;
      longint unsigned f;
      for (int k = 0; k < DEPTH; k++) begin
         y = ((longint'(DEPTH) + k) << 30) / DEPTH;
         f = 0;
         for (int i = 0; i < 24; i++) begin
            y = (y * y) >> 30;
            f = f << 1;
            if (y >= (64'd1 << 31)) begin
               y = y >> 1;
               f = f | 1;
            end
         end
         frac_table[k] = f;
      end
      frac_table[DEPTH] = 64'd1 << 24;
   end

   function automatic longint unsigned log2_fixed(longint unsigned x);
      int e;
      longint unsigned m, off, p, k, r;
      e = 63;
      while (e > 0 && x[e] == 1'b0) e--;
      m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
      off = m - (64'd1 << 30);
      p = off * DEPTH;
      k = p >> 30;
      if (k >= DEPTH) k = DEPTH - 1;
      r = p & ((64'd1 << 30) - 1);
      return (longint'(e) << 24) + frac_table[k]
             + (((frac_table[k+1] - frac_table[k]) * r) >> 30);
   endfunction

   function automatic longint temperature_of(longint unsigned sum);
      longint unsigned num, den, la, lb, mag, lnm, num2;
      longint ln, dd;
      num = sum * 1000;
      den = longint'(NSAMP) * cfg.excite_current_na * cfg.ref_resistance_ohm;
      if (den == 0) return VERY_LOW;
      la = log2_fixed(num);
      lb = log2_fixed(den);
      mag = (lb > la) ? lb - la : la - lb;
      lnm = (mag * ntcah_pkg::LN2_Q24) >> 24;
      ln = (lb > la) ? -longint'(lnm) : longint'(lnm);
      dd = longint'((longint'(cfg.beta_kelvin) * 100) << 24) + 29815 * ln;
      if (dd <= 0) return VERY_LOW;
      num2 = (64'd29815 * cfg.beta_kelvin * 100) << 24;
      return longint'((num2 + longint'(dd) / 2) / longint'(dd)) - 27315;
   endfunction

   task automatic predict_item(logic [21:0] sample, logic [13:0] setpoint);
      heater_result_type res;
      longint t, tout, on_th, off_th;
      logic fault;
      if (acc_count < NSAMP) begin
         acc_sum = acc_sum + sample;
         acc_count = acc_count + 1;
         return;
      end
      fault = (acc_sum <= 100 * NSAMP);
      t = fault ? VERY_LOW : temperature_of(acc_sum);
      acc_sum = '0;
      acc_count = '0;
      on_th = longint'(setpoint) - longint'(cfg.on_offset_centi);
      off_th = longint'(setpoint) - longint'(cfg.off_offset_centi);
      if (!cfg.control_enable) heater_state = 1'b0;
      else if (t <= on_th) heater_state = 1'b1;
      else if (t >= off_th) heater_state = 1'b0;
      tout = (t < -4000) ? -4000 : (t > 15000) ? 15000 : t;
      res.duty = heater_state ? cfg.on_duty : 8'd0;
      res.temp = tout[14:0];
      res.fault = fault;
      expected_results.push_back(res);
   endtask

   always @(posedge clock) begin
      heater_result_type e;
      if (reset) begin
         cfg <= '{1'b1, 8'd5, 11'd200, 11'd150, 20'd101440, 20'd10341, 13'd3576};
         acc_sum = '0;
         acc_count = '0;
         heater_state = 1'b0;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (ntcah_pkg::csr_index_type'(csr_index))
               ntcah_pkg::CSR_ENABLE:  cfg.control_enable     <= csr_data[0];
               ntcah_pkg::CSR_DUTY:    cfg.on_duty            <= csr_data[7:0];
               ntcah_pkg::CSR_ON_OFS:  cfg.on_offset_centi    <= csr_data[10:0];
               ntcah_pkg::CSR_OFF_OFS: cfg.off_offset_centi   <= csr_data[10:0];
               ntcah_pkg::CSR_CURRENT: cfg.excite_current_na  <= csr_data;
               ntcah_pkg::CSR_REF_RES: cfg.ref_resistance_ohm <= csr_data;
               ntcah_pkg::CSR_BETA:    cfg.beta_kelvin        <= csr_data[12:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_item(req_sample_uv, req_setpoint_centi);
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result duty=%0d temp=%0d fault=%0d", $time,
                        rsp_heater_duty, rsp_temperature_centi, rsp_sensor_fault);
               mismatch_count <= mismatch_count + 1;
            end else begin
               e = expected_results.pop_front();
               if (e.duty !== rsp_heater_duty || e.temp !== rsp_temperature_centi ||
                   e.fault !== rsp_sensor_fault) begin
                  $display("%0t: expected duty=%0d temp=%0d fault=%0d, actual %0d %0d %0d",
                           $time, e.duty, e.temp, e.fault, rsp_heater_duty,
                           rsp_temperature_centi, rsp_sensor_fault);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
      pending_count <= expected_results.size();
   end

   initial mismatch_count = 0;
   initial pending_count = 0;
endmodule

// ----- sim/tb_ntc_averaged_hysteresis_heater.sv -----
// Testbench top for the NTC heater controller: stimulus, reset and the verdict.
module tb_ntc_averaged_hysteresis_heater;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOWS = 24;
   localparam int SETTLE  = 300;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [21:0]        req_sample_uv = '0;
   logic [13:0]        req_setpoint_centi = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [7:0]         rsp_heater_duty;
   logic signed [14:0] rsp_temperature_centi;
   logic               rsp_sensor_fault;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [19:0]        csr_data = '0;
   int                 mismatch_count;
   int                 pending_count;
   logic               quiet = 1'b0;
   real                cur_na = 101440.0, res_ohm = 10341.0, beta = 3576.0;

   always #5 clock = ~clock;

   ntc_averaged_hysteresis_heater dut (.*);
   ntcah_checker checker_i (.*);

   initial begin
      forever begin
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         if (!quiet) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
      end
   end

   task automatic send_sample(logic [21:0] sample, logic [13:0] setpoint);
      req_valid <= 1'b1;
      req_sample_uv <= sample;
      req_setpoint_centi <= setpoint;
      do @(posedge clock); while (req_stall);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic csr_write(ntcah_pkg::csr_index_type idx, logic [19:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(int phase);
      logic [19:0] v[7];
      case (phase % 4)
         1: v = '{1, 255, 2047, 0, 20'hFFFFF, 20'hFFFFF, 8191};
         2: v = '{0, 0, 0, 2047, 0, 0, 0};
         3: v = '{1, 1, 0, 0, 1000, 100, 1000};
         default: v = '{$urandom_range(0, 3) != 0, $urandom_range(0, 255),
                        $urandom_range(0, 2000), $urandom_range(0, 2000),
                        $urandom_range(1000, 1000000), $urandom_range(100, 1000000),
                        $urandom_range(1000, 6000)};
      endcase
      for (int i = 0; i < 7; i++) csr_write(ntcah_pkg::csr_index_type'(i), v[i]);
      cur_na = v[4];
      res_ohm = v[5];
      beta = v[6];
   endtask

   // One averaging window plus its evaluating transfer.
   task automatic send_window(int mode);
      real t_c, volts;
      int base, spread, sp, s;
      t_c = $urandom_range(0, 2200) / 10.0 - 60.0;
      if (mode == 0 && cur_na > 0 && res_ohm > 0) begin
         volts = cur_na * res_ohm / 1000.0
                 * $exp(beta * (1.0 / (t_c + 273.15) - 1.0 / 298.15));
         base = (volts > 4194303.0) ? 4194303 : int'(volts);
         spread = base / 50 + 1;
      end else if (mode == 1) begin
         base = $urandom_range(0, 140);
         spread = 20;
      end else begin
         base = $urandom_range(0, 4194303);
         spread = $urandom_range(0, 4194303);
      end
      sp = int'(t_c * 100.0) + $urandom_range(0, 600) - 300;
      if ($urandom_range(0, 7) == 0) sp = $urandom_range(0, 16383);
      if (sp < 0) sp = 0;
      if (sp > 16383) sp = 16383;
      for (int i = 0; i <= 50; i++) begin
         s = base + $urandom_range(0, spread) - spread / 2;
         if (s < 0) s = 0;
         if (s > 4194303) s = 4194303;
         send_sample(22'(s), 14'(sp));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: a window of zero volts, a window of full-scale samples.
      for (int i = 0; i <= 50; i++) send_sample(22'd0, 14'd0);
      for (int i = 0; i <= 50; i++) send_sample(22'h3FFFFF, 14'h3FFF);
      for (int w = 0; w < WINDOWS; w++) begin
         if (w % 5 == 0) begin
            wait_idle();
            configure(w / 5 + 1);
         end
         if (w >= WINDOWS - 6) quiet <= 1'b1;
         send_window($urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 2));
      end
      wait_idle();
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   initial begin
      #5ms;
      $display("Mismatches found");
      $finish;
   end
endmodule
